/* design/gmt_pkg.sv */
// ----------------------------------------------------------------------------
// gmt_pkg
// Shared types, command codes and saturating fixed-point helpers for the
// G-code motion tracker.
// ----------------------------------------------------------------------------
package gmt_pkg;

    // Width of the internal coordinate registers (Q16.16 at 32 bits).
    localparam int COORD_WIDTH = 32;

    // Width of the words on the ports.
    localparam int WORD_WIDTH  = 32;
    localparam int FUNC_WIDTH  = 10;

    localparam int IN_TDATA_WIDTH  = 4 * WORD_WIDTH;
    localparam int IN_TUSER_WIDTH  = FUNC_WIDTH + 4;
    localparam int OUT_TDATA_WIDTH = 6 * WORD_WIDTH;
    localparam int OUT_TUSER_WIDTH = 2;

    localparam logic [FUNC_WIDTH-1:0] CMD_RAPID   = FUNC_WIDTH'(0);
    localparam logic [FUNC_WIDTH-1:0] CMD_LINEAR  = FUNC_WIDTH'(1);
    localparam logic [FUNC_WIDTH-1:0] CMD_RELMOVE = FUNC_WIDTH'(7);
    localparam logic [FUNC_WIDTH-1:0] CMD_ABS     = FUNC_WIDTH'(90);
    localparam logic [FUNC_WIDTH-1:0] CMD_REL     = FUNC_WIDTH'(91);
    localparam logic [FUNC_WIDTH-1:0] CMD_SETPOS  = FUNC_WIDTH'(92);

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_EXTRUDE = 2'd1,
        KIND_TRAVEL  = 2'd2
    } kind_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam logic [63:0] COORD_MAX_U = (64'd1 << (COORD_WIDTH - 1)) - 64'd1;
    localparam logic signed [63:0] COORD_MAX64 = signed'(COORD_MAX_U);
    localparam logic signed [63:0] COORD_MIN64 = ~COORD_MAX64;
    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    localparam logic signed [63:0] WORD_MAX64 = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN64 = -64'sd2147483648;

    // One parsed command, as held in the input register.
    typedef struct packed {
        logic [FUNC_WIDTH-1:0]                func;
        logic [2:0]                           has;
        logic [2:0][WORD_WIDTH-1:0]           val;
        logic                                 has_e;
        logic [WORD_WIDTH-1:0]                e_value;
    } cmd_t;

    // One result, as held in the output register.
    typedef struct packed {
        kind_t                                kind;
        logic [2:0][WORD_WIDTH-1:0]           start_pos;
        logic [2:0][WORD_WIDTH-1:0]           end_pos;
    } res_t;

    function automatic coord_t sat_add(input coord_t a, input coord_t b);
        logic [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        return s[COORD_WIDTH-1:0];
    endfunction

    function automatic coord_t sat_sub(input coord_t a, input coord_t b);
        logic [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        return s[COORD_WIDTH-1:0];
    endfunction

    // Brings a port word into the coordinate range.
    function automatic coord_t to_coord(input logic [WORD_WIDTH-1:0] w);
        logic signed [63:0] wide;
        wide = 64'(signed'(w));
        if (wide > COORD_MAX64)
            return COORD_MAX;
        if (wide < COORD_MIN64)
            return COORD_MIN;
        return wide[COORD_WIDTH-1:0];
    endfunction

    // Clamps a coordinate into the signed range of a port word.
    function automatic logic [WORD_WIDTH-1:0] to_word(input coord_t v);
        logic signed [63:0] wide;
        wide = 64'(v);
        if (wide > WORD_MAX64)
            return WORD_MAX64[WORD_WIDTH-1:0];
        if (wide < WORD_MIN64)
            return WORD_MIN64[WORD_WIDTH-1:0];
        return wide[WORD_WIDTH-1:0];
    endfunction

endpackage

/* design/gcode_motion_tracker.sv */
// ----------------------------------------------------------------------------
// gcode_motion_tracker
// Tracks the tool position across a stream of parsed G commands.
// ----------------------------------------------------------------------------
// Every accepted command yields exactly one result beat, by way of the input
// and output registers, and a new command is accepted in every cycle unless
// the output is stalled. The command is held in an input register, the saturating
// add and subtract on the held position produce the new state and end point
// in one pass, and the result is held in an output register; the position
// registers update when a command moves into the output register, so a
// following command sees the new position without waiting.
module gcode_motion_tracker
    import gmt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // x_value, y_value, z_value, e_value
    input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    // func, has_x, has_y, has_z, has_e
    input  logic [IN_TUSER_WIDTH-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    // move_kind
    output logic [OUT_TUSER_WIDTH-1:0] m_axis_tuser
);

    cmd_t in_reg;
    logic in_valid_reg;
    res_t out_reg;
    logic out_valid_reg;
    res_t res;
    cmd_t in_cmd;
    logic advance;

    assign in_cmd.func    = s_axis_tuser[FUNC_WIDTH-1:0];
    assign in_cmd.has     = s_axis_tuser[FUNC_WIDTH+2:FUNC_WIDTH];
    assign in_cmd.has_e   = s_axis_tuser[FUNC_WIDTH+3];
    assign in_cmd.val[0]  = s_axis_tdata[WORD_WIDTH-1:0];
    assign in_cmd.val[1]  = s_axis_tdata[2*WORD_WIDTH-1:WORD_WIDTH];
    assign in_cmd.val[2]  = s_axis_tdata[3*WORD_WIDTH-1:2*WORD_WIDTH];
    assign in_cmd.e_value = s_axis_tdata[4*WORD_WIDTH-1:3*WORD_WIDTH];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    gmt_state_unit u_state
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (in_reg),
        .advance (advance),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_reg <= in_cmd;
        if (advance)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {out_reg.end_pos[2], out_reg.end_pos[1], out_reg.end_pos[0],
                            out_reg.start_pos[2], out_reg.start_pos[1],
                            out_reg.start_pos[0]};

    // An empty input register never holds off the upstream side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled with an empty input register");

    // A held command moves on when the output register is free.
    a_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("command did not reach the output register");

    // A stalled result beat stays put until the downstream side takes it.
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

endmodule

/* design/gmt_state_unit.sv */
// ----------------------------------------------------------------------------
// gmt_state_unit
// Holds the logical position, axis offsets, absolute position and mode, and
// works out the result of the command in the input register.
// ----------------------------------------------------------------------------
module gmt_state_unit
    import gmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  logic advance,
    output res_t res
);

    coord_t log_reg  [3];
    coord_t off_reg  [3];
    coord_t abs_reg  [3];
    logic   mode_reg;

    coord_t log_next [3];
    coord_t off_next [3];
    coord_t abs_next [3];
    logic   mode_next;

    coord_t val_c    [3];
    coord_t log_sum  [3];
    kind_t  kind;
    logic   rel;
    logic   e_positive;

    assign e_positive = !cmd.e_value[WORD_WIDTH-1] && (cmd.e_value != '0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            val_c[i]    = to_coord(cmd.val[i]);
            log_sum[i]  = sat_add(log_reg[i], val_c[i]);
            log_next[i] = log_reg[i];
            off_next[i] = off_reg[i];
        end
        mode_next = mode_reg;
        kind      = KIND_NONE;
        rel       = (cmd.func == CMD_RELMOVE) || !mode_reg;

        case (cmd.func)
            CMD_RAPID, CMD_LINEAR, CMD_RELMOVE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.has[i])
                        log_next[i] = rel ? log_sum[i] : val_c[i];
                end
                if (cmd.has_e && e_positive)
                    kind = KIND_EXTRUDE;
                else if (cmd.has != 3'b000)
                    kind = KIND_TRAVEL;
            end
            CMD_ABS:
            begin
                mode_next = 1'b1;
            end
            CMD_REL:
            begin
                mode_next = 1'b0;
            end
            CMD_SETPOS:
            begin
                // A bare set-position zeroes the logical position and folds
                // the whole absolute position into the offsets.
                if (cmd.has == 3'b000 && !cmd.has_e)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        off_next[i] = abs_reg[i];
                        log_next[i] = '0;
                    end
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (cmd.has[i])
                        begin
                            log_next[i] = val_c[i];
                            off_next[i] = sat_sub(abs_reg[i], val_c[i]);
                        end
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        for (int i = 0; i < 3; i++)
        begin
            abs_next[i]         = sat_add(off_next[i], log_next[i]);
            res.start_pos[i]    = to_word(abs_reg[i]);
            res.end_pos[i]      = to_word(abs_next[i]);
        end
        res.kind = kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                log_reg[i] <= '0;
                off_reg[i] <= '0;
                abs_reg[i] <= '0;
            end
            mode_reg <= 1'b1;
        end
        else if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                log_reg[i] <= log_next[i];
                off_reg[i] <= off_next[i];
                abs_reg[i] <= abs_next[i];
            end
            mode_reg <= mode_next;
        end
    end

    // The held absolute X position always matches offset plus logical X position.
    a_abs_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        abs_reg[0] == sat_add(off_reg[0], log_reg[0]))
        else $error("absolute X out of step with offset and logical X");

    // Commands other than moves and set-position leave the position untouched.
    a_other_stable: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cmd.func != CMD_RAPID && cmd.func != CMD_LINEAR &&
        cmd.func != CMD_RELMOVE && cmd.func != CMD_SETPOS
        |=> $stable(abs_reg[0]) && $stable(abs_reg[1]) && $stable(abs_reg[2]))
        else $error("position changed on a non-motion command");

    // Mode commands take effect on the next command.
    a_mode_rel: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cmd.func == CMD_REL |=> !mode_reg)
        else $error("relative mode not set");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: gcode_motion_tracker testbench
// Streams parsed G commands into the motion tracker and checks every result
// beat against a position tracker kept inside the testbench. A short directed
// sequence covers modes, saturation, G92 variants and unknown commands.
// Random phases follow, with different amounts of source idling and sink
// stalling. One phase holds the sink off for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module tb_top
    import gmt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 100;
    localparam int MAX_REPORTS  = 40;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_ZERO = 32'h0000_0000;

    localparam logic [2:0] AX_NONE = 3'b000;
    localparam logic [2:0] AX_X    = 3'b001;
    localparam logic [2:0] AX_Y    = 3'b010;
    localparam logic [2:0] AX_Z    = 3'b100;
    localparam logic [2:0] AX_ALL  = 3'b111;

    typedef struct packed {
        logic [FUNC_WIDTH-1:0] func;
        logic [2:0]            has;
        logic [2:0][31:0]      word;
        logic                  has_e;
        logic [31:0]           e_value;
    } gcmd_t;

    typedef struct packed {
        kind_t            kind;
        logic [2:0][31:0] start_pt;
        logic [2:0][31:0] end_pt;
    } motion_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_WIDTH-1:0]  s_axis_tuser = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;
    logic [OUT_TUSER_WIDTH-1:0] m_axis_tuser;

    gcmd_t   pending_cmds[$];
    motion_t expected_moves[$];
    gcmd_t   offered;

    logic signed [63:0] trk_logical [3];
    logic signed [63:0] trk_offset [3];
    logic               trk_absolute;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   errors = 0;
    int   idle_cycles = 0;
    logic long_hold_go = 1'b0;
    logic results_held = 1'b0;
    string axis_name [3] = '{"x", "y", "z"};

    gcode_motion_tracker DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic signed [63:0] clamp_coord(input logic signed [63:0] v);
        if (v > COORD_MAX64)
            return COORD_MAX64;
        if (v < COORD_MIN64)
            return COORD_MIN64;
        return v;
    endfunction

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        return clamp_coord(a + b);
    endfunction

    function automatic logic [31:0] port_word(input logic signed [63:0] v);
        if (v > WORD_MAX64)
            return WORD_MAX64[31:0];
        if (v < WORD_MIN64)
            return WORD_MIN64[31:0];
        return v[31:0];
    endfunction

    // Applies one command to the tracked position and returns the result beat.
    function automatic motion_t track_command(input gcmd_t c);
        logic signed [63:0] from_pt [3];
        logic signed [63:0] w;
        logic               relative;
        logic               any_axis;
        motion_t            m;
        int                 i;
        m.kind = KIND_NONE;
        any_axis = |c.has;
        for (i = 0; i < 3; i++)
            from_pt[i] = sat_sum(trk_offset[i], trk_logical[i]);
        if (c.func == CMD_RAPID || c.func == CMD_LINEAR || c.func == CMD_RELMOVE)
        begin
            relative = (c.func == CMD_RELMOVE) || !trk_absolute;
            for (i = 0; i < 3; i++)
            begin
                if (c.has[i])
                begin
                    w = clamp_coord(signed'(c.word[i]));
                    trk_logical[i] = relative ? sat_sum(trk_logical[i], w) : w;
                end
            end
            if (c.has_e && signed'(c.e_value) > 0)
                m.kind = KIND_EXTRUDE;
            else if (any_axis)
                m.kind = KIND_TRAVEL;
        end
        else if (c.func == CMD_ABS)
            trk_absolute = 1'b1;
        else if (c.func == CMD_REL)
            trk_absolute = 1'b0;
        else if (c.func == CMD_SETPOS)
        begin
            // A bare G92 moves the whole absolute position into the offset.
            if (!any_axis && !c.has_e)
            begin
                for (i = 0; i < 3; i++)
                begin
                    trk_offset[i] = from_pt[i];
                    trk_logical[i] = '0;
                end
            end
            else
            begin
                for (i = 0; i < 3; i++)
                begin
                    if (c.has[i])
                    begin
                        w = clamp_coord(signed'(c.word[i]));
                        trk_logical[i] = w;
                        trk_offset[i] = clamp_coord(from_pt[i] - w);
                    end
                end
            end
        end
        for (i = 0; i < 3; i++)
        begin
            m.start_pt[i] = port_word(from_pt[i]);
            m.end_pt[i] = port_word(sat_sum(trk_offset[i], trk_logical[i]));
        end
        return m;
    endfunction

    function automatic logic [31:0] rand_word();
        int s;
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return Q_ZERO;
            3, 4, 5:
            begin
                s = $urandom_range(0, 1 << 24) - (1 << 23);
                return s;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_cmd(input logic [FUNC_WIDTH-1:0] func, input logic [2:0] has,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic has_e,
                             input logic [31:0] e);
        gcmd_t c;
        c.func = func;
        c.has = has;
        c.word[0] = x;
        c.word[1] = y;
        c.word[2] = z;
        c.has_e = has_e;
        c.e_value = e;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic queue_random_cmds(input int count);
        logic [FUNC_WIDTH-1:0] func;
        int                    pick;
        int                    n;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                func = CMD_LINEAR;
            else if (pick < 45)
                func = CMD_RAPID;
            else if (pick < 57)
                func = CMD_RELMOVE;
            else if (pick < 63)
                func = CMD_ABS;
            else if (pick < 69)
                func = CMD_REL;
            else if (pick < 80)
                func = CMD_SETPOS;
            else
                func = FUNC_WIDTH'($urandom_range(0, 1023));
            queue_cmd(func, 3'($urandom_range(0, 7)), rand_word(), rand_word(), rand_word(),
                      1'($urandom_range(0, 1)), rand_word());
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s got %h expected %h", $time, field, got, want);
    endtask

    task automatic check_move();
        motion_t want;
        int      i;
        if (expected_moves.size() == 0)
        begin
            report_mismatch("result beat with no command pending", 32'(m_axis_tuser), 0);
            return;
        end
        want = expected_moves.pop_front();
        if (m_axis_tuser != want.kind)
            report_mismatch("move_kind", 32'(m_axis_tuser), 32'(want.kind));
        for (i = 0; i < 3; i++)
        begin
            if (m_axis_tdata[32*i +: 32] != want.start_pt[i])
                report_mismatch({"start_", axis_name[i]}, m_axis_tdata[32*i +: 32],
                                want.start_pt[i]);
            if (m_axis_tdata[96 + 32*i +: 32] != want.end_pt[i])
                report_mismatch({"end_", axis_name[i]}, m_axis_tdata[96 + 32*i +: 32],
                                want.end_pt[i]);
        end
    endtask

    // Returns at a falling edge once no command or result is outstanding.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_moves.size() != 0)
            @(negedge clk);
    endtask

    // Source side: the tracker is updated at the edge where a beat is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_moves.insert(expected_moves.size(), track_command(offered));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_cmds.pop_front();
                    s_axis_tdata <= {offered.e_value, offered.word};
                    s_axis_tuser <= {offered.has_e, offered.has, offered.func};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_move();
            m_axis_tready <= !results_held && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long sink hold-off, counted here while the source keeps offering beats.
    initial
    begin
        wait (long_hold_go);
        @(negedge clk);
        results_held = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        results_held = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            trk_logical[i] = '0;
            trk_offset[i] = '0;
        end
        trk_absolute = 1'b1;

        queue_cmd(CMD_RAPID, AX_NONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, Q_ZERO);
        queue_cmd(CMD_LINEAR, AX_ALL, Q_MAX, Q_MIN, Q_ONE, 1'b1, Q_ONE);
        // An E word of zero or below is not extrusion.
        queue_cmd(CMD_LINEAR, AX_X, Q_ONE, Q_ZERO, Q_ZERO, 1'b1, Q_ZERO);
        queue_cmd(CMD_LINEAR, AX_Y, Q_ZERO, -Q_ONE, Q_ZERO, 1'b1, Q_MIN);
        queue_cmd(CMD_RELMOVE, AX_NONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, Q_MAX);
        queue_cmd(CMD_RELMOVE, AX_X | AX_Y, Q_MAX, Q_MIN, Q_ZERO, 1'b0, Q_ZERO);
        queue_cmd(CMD_REL, AX_NONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, Q_ZERO);
        queue_cmd(CMD_RAPID, AX_Z, Q_ZERO, Q_ZERO, Q_MIN, 1'b0, Q_ZERO);
        queue_cmd(CMD_LINEAR, AX_Z, Q_ZERO, Q_ZERO, Q_MIN, 1'b1, Q_ONE);
        queue_cmd(CMD_LINEAR, AX_NONE, Q_MAX, Q_MAX, Q_MAX, 1'b0, Q_ONE);
        queue_cmd(CMD_SETPOS, AX_NONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, Q_ZERO);
        queue_cmd(CMD_LINEAR, AX_X, 5 * Q_ONE, Q_ZERO, Q_ZERO, 1'b0, Q_ZERO);
        queue_cmd(CMD_SETPOS, AX_X, Q_MAX, Q_ZERO, Q_ZERO, 1'b0, Q_ZERO);
        queue_cmd(CMD_SETPOS, AX_NONE, Q_ONE, Q_ONE, Q_ONE, 1'b1, Q_ONE);
        queue_cmd(CMD_SETPOS, AX_Y | AX_Z, Q_ZERO, Q_MIN, Q_MAX, 1'b0, Q_ZERO);
        queue_cmd(CMD_ABS, AX_NONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, Q_ZERO);
        queue_cmd(CMD_RAPID, AX_ALL, Q_MIN, Q_MAX, Q_ZERO, 1'b0, Q_ZERO);
        queue_cmd(10'd1023, AX_ALL, Q_ONE, Q_ONE, Q_ONE, 1'b1, Q_ONE);
        queue_cmd(10'd2, AX_ALL, Q_MAX, Q_MAX, Q_MAX, 1'b1, Q_MAX);
        queue_cmd(10'd93, AX_X, Q_MIN, Q_ZERO, Q_ZERO, 1'b0, Q_ZERO);
        queue_cmd(CMD_RELMOVE, AX_ALL, Q_MIN, Q_MIN, Q_MIN, 1'b1, -Q_ONE);
        queue_cmd(CMD_SETPOS, AX_NONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, Q_ZERO);
        queue_cmd(CMD_LINEAR, AX_ALL, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, Q_MAX);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        queue_random_cmds(130);
        wait_drained();
        send_idle_pct = 57;
        queue_random_cmds(130);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 57;
        queue_random_cmds(130);
        wait_drained();
        send_idle_pct = 6;
        recv_stall_pct = 6;
        queue_random_cmds(130);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold_go = 1'b1;
        queue_random_cmds(40);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_moves.size() != 0)
            report_mismatch("commands left without result", expected_moves.size(), 0);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
design/gmt_pkg.sv
design/gmt_state_unit.sv
design/gcode_motion_tracker.sv
verif/tb_top.sv
